>>> src/aafe_pkg.sv
// Package for the angle ASCII frame encoder: payload structs, microcode word
// layout and the microcode program table. No dependencies.
package aafe_pkg;

    localparam int unsigned GroupW   = 12;
    localparam int unsigned NumDigit = 5;
    localparam int unsigned StepW    = 3;
    localparam int unsigned DigIdxW  = $clog2(NumDigit);
    localparam int unsigned AddrW    = 3;

    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;

    // Reciprocal of ten: x / 10 == (x * DivMul) >> DivShift for any 16-bit x
    localparam logic [15:0] DivMul   = 16'd52429;
    localparam int unsigned DivShift = 19;

    localparam logic [GroupW-1:0] GroupIdReset = 12'h101;

    // Register index, taken from paddr[2]
    localparam logic RegGroupId = 1'b0;

    typedef struct packed {
        logic        [7:0]  id_char;
        logic signed [15:0] angle_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_item;

    typedef enum logic [2:0] {
        SRC_G2,
        SRC_G1,
        SRC_G0,
        SRC_ID,
        SRC_SIGN,
        SRC_DIG,
        SRC_CR,
        SRC_LF
    } t_src;

    typedef struct packed {
        t_src src;   // byte source for this step
        logic conv;  // run one divide-by-ten step on the magnitude
        logic loop;  // repeat this step while digits remain
        logic fin;   // last step of the frame
    } t_uop;

    function automatic t_uop ucode(input logic [StepW-1:0] step);
        t_uop u;
        u = '{src: SRC_G2, conv: 1'b0, loop: 1'b0, fin: 1'b0};
        unique case (step)
            3'd0: u = '{src: SRC_G2,   conv: 1'b1, loop: 1'b0, fin: 1'b0};
            3'd1: u = '{src: SRC_G1,   conv: 1'b1, loop: 1'b0, fin: 1'b0};
            3'd2: u = '{src: SRC_G0,   conv: 1'b1, loop: 1'b0, fin: 1'b0};
            3'd3: u = '{src: SRC_ID,   conv: 1'b1, loop: 1'b0, fin: 1'b0};
            3'd4: u = '{src: SRC_SIGN, conv: 1'b1, loop: 1'b0, fin: 1'b0};
            3'd5: u = '{src: SRC_DIG,  conv: 1'b0, loop: 1'b1, fin: 1'b0};
            3'd6: u = '{src: SRC_CR,   conv: 1'b0, loop: 1'b0, fin: 1'b0};
            3'd7: u = '{src: SRC_LF,   conv: 1'b0, loop: 1'b0, fin: 1'b1};
        endcase
        return u;
    endfunction

endpackage

>>> src/angle_ascii_frame_encoder.sv
// Angle ASCII frame encoder top level: microcode sequencer, digit datapath
// and APB register. Depends on aafe_pkg.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the frame is finished. The frame is 7 + N bytes, N being the number
// of decimal digits of the magnitude (1 to 5), one byte per cycle, each shown
// for exactly one cycle with o_strobe, both registered from its microcode
// step; the receiver must take every byte as it comes. The program runs one
// step per cycle, and a new item is taken only after busy has dropped at
// the end of the previous frame. The five divide-by-ten steps that split the
// magnitude into digits run in parallel with the five header bytes, so they
// need no steps of their own. The group id register is read while the first
// three bytes are built; write it only while busy is low.
module angle_ascii_frame_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  aafe_pkg::t_in_item            i_in,
    output logic                          o_strobe,
    output aafe_pkg::t_out_item           o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aafe_pkg::AddrW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic                               r_busy;
    logic [aafe_pkg::StepW-1:0]         r_step;
    logic [aafe_pkg::DigIdxW-1:0]       r_top;
    logic [15:0]                        r_mag;
    logic [7:0]                         r_id;
    logic                               r_neg;
    logic [3:0]                         r_digit [aafe_pkg::NumDigit];
    logic [aafe_pkg::GroupW-1:0]        r_grp_num;
    logic                               r_strobe;
    aafe_pkg::t_out_item                r_result;

    aafe_pkg::t_uop                     uop;
    aafe_pkg::t_out_item                n_result;
    logic                               accept;
    logic [15:0]                        in_mag;
    logic [31:0]                        prod;
    logic [12:0]                        quot;
    logic [15:0]                        quot_x10;
    logic [15:0]                        rem_full;
    logic [3:0]                         rem;

    assign accept = start && !r_busy;
    assign uop    = aafe_pkg::ucode(r_step);

    // Two's complement magnitude; -32768 maps to 16'h8000
    assign in_mag = i_in.angle_value[15] ? (~i_in.angle_value + 16'd1)
                                         : i_in.angle_value;

    // Divide by ten through the reciprocal
    assign prod     = r_mag * aafe_pkg::DivMul;
    assign quot     = prod[31:aafe_pkg::DivShift];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem_full = r_mag - quot_x10;
    assign rem      = rem_full[3:0];

    always_comb begin
        n_result.last_byte = uop.fin;
        unique case (uop.src)
            aafe_pkg::SRC_G2:   n_result.frame_byte = aafe_pkg::ChZero + {4'b0, r_grp_num[11:8]};
            aafe_pkg::SRC_G1:   n_result.frame_byte = aafe_pkg::ChZero + {4'b0, r_grp_num[7:4]};
            aafe_pkg::SRC_G0:   n_result.frame_byte = aafe_pkg::ChZero + {4'b0, r_grp_num[3:0]};
            aafe_pkg::SRC_ID:   n_result.frame_byte = r_id;
            aafe_pkg::SRC_SIGN: n_result.frame_byte = r_neg ? aafe_pkg::ChMinus
                                                            : aafe_pkg::ChPlus;
            aafe_pkg::SRC_DIG:  n_result.frame_byte = aafe_pkg::ChZero + {4'b0, r_digit[r_top]};
            aafe_pkg::SRC_CR:   n_result.frame_byte = aafe_pkg::ChCr;
            aafe_pkg::SRC_LF:   n_result.frame_byte = aafe_pkg::ChLf;
            default:            n_result.frame_byte = aafe_pkg::ChZero;
        endcase
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= '0;
            r_top    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_top  <= '0;
                r_mag  <= in_mag;
                r_id   <= i_in.id_char;
                r_neg  <= i_in.angle_value[15];
            end else if (r_busy) begin
                r_result <= n_result;
                if (uop.conv) begin
                    r_digit[r_step[aafe_pkg::DigIdxW-1:0]] <= rem;
                    r_mag <= {3'b000, quot};
                    // Track the highest digit that belongs to the number
                    if (r_mag != 16'd0) begin
                        r_top <= r_step[aafe_pkg::DigIdxW-1:0];
                    end
                end
                // Hold on the digit step until the lowest digit is out
                if (uop.loop && r_top != '0) begin
                    r_top <= r_top - 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
                if (uop.fin) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_num <= aafe_pkg::GroupIdReset;
        end else if (psel && penable && pwrite && paddr[2] == aafe_pkg::RegGroupId) begin
            r_grp_num <= pwdata[aafe_pkg::GroupW-1:0];
        end
    end

    assign prdata   = (paddr[2] == aafe_pkg::RegGroupId)
                      ? {{(32 - aafe_pkg::GroupW){1'b0}}, r_grp_num} : 32'd0;
    assign pready   = 1'b1;
    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_busy))
        else $error("byte strobed without an active frame");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_byte) |-> !r_busy)
        else $error("sequencer still busy after the closing byte");

    a_accept_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && r_step == '0 && r_top == '0))
        else $error("program did not restart on an accepted item");

    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_top < aafe_pkg::DigIdxW'(aafe_pkg::NumDigit)))
        else $error("digit index out of range");

endmodule

>>> tb/sv/tb_angle_ascii_frame_encoder.sv
// Testbench for angle_ascii_frame_encoder: drives angle samples, predicts each ASCII
// frame byte by byte and checks every strobed byte, across several group id settings.
// Depends on aafe_pkg and the angle_ascii_frame_encoder RTL.
module tb_angle_ascii_frame_encoder;

    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned SettleCycles = 16;
    localparam int unsigned IdlePct      = 8;
    localparam int unsigned QuietFrom    = 90;
    localparam int unsigned QuietTo      = 150;

    localparam logic [7:0] AsciiZero  = 8'h30;
    localparam logic [7:0] AsciiMinus = 8'h2D;
    localparam logic [7:0] AsciiPlus  = 8'h2B;
    localparam logic [7:0] AsciiCr    = 8'h0D;
    localparam logic [7:0] AsciiLf    = 8'h0A;

    localparam logic [aafe_pkg::GroupW-1:0] GroupIdAtReset = 12'h101;
    localparam logic [aafe_pkg::AddrW-1:0]  GroupIdAddr    = {aafe_pkg::RegGroupId, 2'b00};
    localparam logic [aafe_pkg::AddrW-1:0]  SpareAddr      = {~aafe_pkg::RegGroupId, 2'b00};

    typedef struct {
        aafe_pkg::t_in_item payload;
        bit                 drain_first;
    } t_angle_req;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start   = 1'b0;
    aafe_pkg::t_in_item         i_in    = '0;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [aafe_pkg::AddrW-1:0] paddr   = '0;
    logic [31:0]                pwdata  = '0;
    logic                       busy;
    logic                       o_strobe;
    aafe_pkg::t_out_item        o_result;
    logic [31:0]                prdata;
    logic                       pready;

    t_angle_req                  angle_queue[$];
    aafe_pkg::t_out_item         frame_bytes_due[$];
    logic [aafe_pkg::GroupW-1:0] grp_num_model = GroupIdAtReset;
    int unsigned                 mismatches    = 0;
    int unsigned                 items_taken   = 0;
    int unsigned                 cycle_count   = 0;
    logic                        taken;
    aafe_pkg::t_out_item         due_byte;

    angle_ascii_frame_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Build the expected frame for one taken sample under the current group id.
    function automatic void predict_frame(input aafe_pkg::t_in_item sample);
        logic [7:0] digit_chars[5];
        int         mag;
        int         n;
        mag = int'(sample.angle_value);
        if (mag < 0) mag = -mag;
        n = 0;
        frame_bytes_due.push_back(aafe_pkg::t_out_item'{
            AsciiZero + {4'b0, grp_num_model[11:8]}, 1'b0});
        frame_bytes_due.push_back(aafe_pkg::t_out_item'{
            AsciiZero + {4'b0, grp_num_model[7:4]}, 1'b0});
        frame_bytes_due.push_back(aafe_pkg::t_out_item'{
            AsciiZero + {4'b0, grp_num_model[3:0]}, 1'b0});
        frame_bytes_due.push_back(aafe_pkg::t_out_item'{sample.id_char, 1'b0});
        frame_bytes_due.push_back(aafe_pkg::t_out_item'{
            (sample.angle_value < 0) ? AsciiMinus : AsciiPlus, 1'b0});
        do begin
            digit_chars[n] = AsciiZero + 8'(mag % 10);
            n++;
            mag = mag / 10;
        end while (mag > 0);
        for (int k = n - 1; k >= 0; k--) begin
            frame_bytes_due.push_back(aafe_pkg::t_out_item'{digit_chars[k], 1'b0});
        end
        frame_bytes_due.push_back(aafe_pkg::t_out_item'{AsciiCr, 1'b0});
        frame_bytes_due.push_back(aafe_pkg::t_out_item'{AsciiLf, 1'b1});
    endfunction

    // Pick a digit count first so short and long magnitudes show up evenly.
    function automatic aafe_pkg::t_in_item random_angle();
        aafe_pkg::t_in_item sample;
        int       tens[6] = '{1, 10, 100, 1000, 10000, 100000};
        int       digits;
        int       lo;
        int       hi;
        int       mag;
        bit       neg;
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(2))
                0:       sample.id_char = "R";
                1:       sample.id_char = "C";
                default: sample.id_char = "O";
            endcase
        end else begin
            sample.id_char = 8'($urandom);
        end
        if ($urandom_range(5) == 0) begin
            sample.angle_value = 16'($urandom);
        end else begin
            digits = $urandom_range(5, 1);
            lo = (digits == 1) ? 0 : tens[digits-1];
            hi = tens[digits] - 1;
            if (hi > 32768) hi = 32768;
            mag = $urandom_range(hi, lo);
            neg = (mag == 32768) ? 1'b1 : 1'($urandom_range(1));
            sample.angle_value = 16'(neg ? -mag : mag);
        end
        return sample;
    endfunction

    task automatic queue_random(input int count, input int drain_at);
        for (int k = 0; k < count; k++) begin
            angle_queue.push_back(t_angle_req'{random_angle(), k == drain_at});
        end
    endtask

    task automatic queue_angle(input logic [7:0] id, input logic signed [15:0] value);
        angle_queue.push_back(t_angle_req'{aafe_pkg::t_in_item'{id, value}, 1'b0});
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (angle_queue.size() != 0 || start || busy || frame_bytes_due.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [aafe_pkg::AddrW-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == GroupIdAddr) grp_num_model = data[aafe_pkg::GroupW-1:0];
    endtask

    task automatic check_grp_num();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= GroupIdAddr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (prdata !== 32'(grp_num_model)) begin
            $display("%0t: group number read expected %h actual %h",
                     $time, 32'(grp_num_model), prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold start until the item is taken; pause or idle only between items.
    always @(posedge i_clk) begin : drive_items
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                predict_frame(i_in);
                void'(angle_queue.pop_front());
                items_taken++;
            end
            if (taken || !start) begin
                if (angle_queue.size() == 0 ||
                    (angle_queue[0].drain_first &&
                     (frame_bytes_due.size() != 0 || busy))) begin
                    start <= 1'b0;
                end else if ((items_taken < QuietFrom || items_taken >= QuietTo) &&
                             $urandom_range(99) < IdlePct) begin
                    start <= 1'b0;
                end else begin
                    start <= 1'b1;
                    i_in  <= angle_queue[0].payload;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_bytes
        if (i_rst_n && o_strobe) begin
            if (frame_bytes_due.size() == 0) begin
                $display("%0t: unexpected byte expected none actual %h last %b",
                         $time, o_result.frame_byte, o_result.last_byte);
                mismatches++;
            end else begin
                due_byte = frame_bytes_due.pop_front();
                if (o_result.frame_byte !== due_byte.frame_byte) begin
                    $display("%0t: frame_byte expected %h actual %h",
                             $time, due_byte.frame_byte, o_result.frame_byte);
                    mismatches++;
                end
                if (o_result.last_byte !== due_byte.last_byte) begin
                    $display("%0t: last_byte expected %b actual %b",
                             $time, due_byte.last_byte, o_result.last_byte);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb_angle_ascii_frame_encoder failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset group id, field extremes, digit-count boundaries, zero, most negative.
        check_grp_num();
        queue_angle(8'h00, 16'sd0);
        queue_angle(8'hFF, 16'sd1);
        queue_angle("R", -16'sd1);
        queue_angle("C", 16'sd9);
        queue_angle("O", 16'sd10);
        queue_angle(8'h80, -16'sd10);
        queue_angle(8'h7F, 16'sd99);
        queue_angle(8'h55, 16'sd100);
        queue_angle(8'hAA, -16'sd999);
        queue_angle("R", 16'sd1000);
        queue_angle("C", 16'sd9999);
        queue_angle("O", -16'sd10000);
        queue_angle(8'h01, 16'sd32767);
        queue_angle(8'hFE, -16'sd32768);
        queue_angle(8'h40, -16'sd32767);
        queue_angle(8'h20, 16'sd12345);
        queue_angle(8'h0F, -16'sd9);
        wait_idle();

        // All nibbles above nine: expect '?' rather than the hex letter F.
        write_reg(GroupIdAddr, 32'h0000_0FFF);
        check_grp_num();
        queue_random(40, 20);
        wait_idle();

        write_reg(GroupIdAddr, 32'h0000_0000);
        check_grp_num();
        queue_random(40, -1);
        wait_idle();

        // Unmapped address: group id must not move.
        write_reg(SpareAddr, 32'h0000_05A5);
        check_grp_num();
        queue_random(40, 10);
        wait_idle();

        write_reg(GroupIdAddr, 32'($urandom_range(4095)));
        check_grp_num();
        queue_random(60, 30);
        wait_idle();

        write_reg(GroupIdAddr, 32'h0000_09AF);
        check_grp_num();
        queue_random(60, -1);
        wait_idle();

        // Upper data bits set: only the low twelve land.
        write_reg(GroupIdAddr, 32'hFFFF_F123);
        check_grp_num();
        queue_random(20, 5);
        wait_idle();

        if (mismatches == 0) begin
            $display("tb_angle_ascii_frame_encoder passed");
        end else begin
            $display("tb_angle_ascii_frame_encoder failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/aafe_pkg.sv
src/angle_ascii_frame_encoder.sv
tb/sv/tb_angle_ascii_frame_encoder.sv
